/* design/i2cm_pkg.sv */
package i2cm_pkg;

  // Item codes carried in the func field.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 8'd1;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  // Which byte is on the wire.
  localparam logic [1:0] STAGE_ADDR    = 2'd0;
  localparam logic [1:0] STAGE_SUB     = 2'd1;
  localparam logic [1:0] STAGE_DATA    = 2'd2;
  localparam logic [1:0] STAGE_RD_ADDR = 2'd3;

  typedef enum logic [15:0] {
    S_IDLE        = 16'h0001,
    S_START_SETUP = 16'h0002,
    S_START_HOLD  = 16'h0004,
    S_TX_LOW      = 16'h0008,
    S_TX_HIGH     = 16'h0010,
    S_ACK_LOW     = 16'h0020,
    S_ACK_HIGH    = 16'h0040,
    S_ACK_POLL    = 16'h0080,
    S_RS_LOW      = 16'h0100,
    S_RX_LOW      = 16'h0200,
    S_RX_HIGH     = 16'h0400,
    S_MACK_LOW    = 16'h0800,
    S_MACK_HIGH   = 16'h1000,
    S_STOP_LOW    = 16'h2000,
    S_STOP_HIGH   = 16'h4000,
    S_STOP_REL    = 16'h8000
  } seq_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] slave_addr;
    logic [7:0] sub_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ok;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
  } res_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

/* design/i2cm_cmd_if.sv */
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] slave_addr;
  logic [7:0] sub_addr;
  logic [7:0] write_data;
  logic [7:0] read_count;
  logic       sda_in;

  modport source (output valid, func, slave_addr, sub_addr, write_data, read_count, sda_in,
                  input ready);
  modport sink (input valid, func, slave_addr, sub_addr, write_data, read_count, sda_in,
                output ready);
endinterface

/* design/i2cm_res_if.sv */
interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic       ok;
  logic [7:0] read_data;
  logic       read_valid;
  logic       read_last;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, ok, read_data,
                  read_valid, read_last, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, ok, read_data,
                read_valid, read_last, output ready);
endinterface

/* design/i2cm_cfg_if.sv */
interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/i2c_master_register_access.sv */
// I2C master for single register writes and burst register reads. Each item on
// the cmd channel either starts a transaction (func write or read, taken only
// while the bus is idle; otherwise it is ignored) or is a tick that advances
// the bus by one tick and carries the sampled SDA level. Every item yields
// exactly one result item with the SCL/SDA drive levels after that item, the
// busy flag, a done/ok pulse when a transaction ends, and a received byte with
// its valid and last flags. One bus phase lasts phase_ticks tick items (0 acts
// as 1); an ACK is polled on every tick after a full SCL high phase, and after
// ack_timeout further high polls the block sends STOP and reports done with ok
// low. A read count of 0 reads one byte. Throughput is one item per clock
// cycle while results are taken, set by the combinational sequencer update
// between the input register and the result register. An item's result is
// offered by the result register after the sequencer steps on the item in
// the input register. While a result waits to be taken, the input register can
// still take one more item. Configuration writes are always accepted and
// should be issued only while the block is idle.
module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int unsigned MAX_READ_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst,
  i2cm_cmd_if.sink    cmd,
  i2cm_res_if.source  res,
  i2cm_cfg_if.sink    cfg
);

  cfg_t  regs;
  item_t in_item;
  logic  in_valid;
  logic  advance;
  res_t  step_res;
  res_t  out_res;

  // The sequencer steps when the input register holds an item and the result
  // register is free or is being emptied in this cycle.
  assign advance   = in_valid && (!res.valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item.func       <= cmd.func;
      in_item.slave_addr <= cmd.slave_addr;
      in_item.sub_addr   <= cmd.sub_addr;
      in_item.write_data <= cmd.write_data;
      in_item.read_count <= cmd.read_count;
      in_item.sda_in     <= cmd.sda_in;
    end
  end

  i2cm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  i2cm_seq #(
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .regs (regs),
    .res  (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.scl_out    = out_res.scl_out;
  assign res.sda_out    = out_res.sda_out;
  assign res.busy_res   = out_res.busy_res;
  assign res.done_res   = out_res.done_res;
  assign res.ok         = out_res.ok;
  assign res.read_data  = out_res.read_data;
  assign res.read_valid = out_res.read_valid;
  assign res.read_last  = out_res.read_last;

endmodule

/* design/i2cm_cfg_regs.sv */
module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2cm_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.phase_ticks <= PHASE_TICKS_RESET;
      regs.ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PHASE_TICKS: regs.phase_ticks <= cfg.data;
        CFG_ACK_TIMEOUT: regs.ack_timeout <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* design/i2cm_seq.sv */
module i2cm_seq
  import i2cm_pkg::*;
#(
  parameter int unsigned MAX_READ_BYTES = 255
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  regs,
  output res_t  res
);

  localparam logic [15:0] MaxRead = 16'(MAX_READ_BYTES);

  seq_state_t seq_state, seq_state_next;
  logic [7:0] phase_count, phase_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] ack_wait_count, ack_wait_count_next;
  logic       is_read, is_read_next;
  logic [6:0] latched_addr, latched_addr_next;
  logic [7:0] latched_sub, latched_sub_next;
  logic [7:0] latched_data, latched_data_next;
  logic [1:0] tx_stage, tx_stage_next;

  logic [7:0] plen;
  logic [8:0] pc_inc;
  logic [3:0] bc_inc;
  logic [7:0] rx_shift;
  logic [7:0] cnt;
  logic       last_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state      <= S_IDLE;
      phase_count    <= '0;
      bit_count      <= '0;
      shift_reg      <= '0;
      bytes_left     <= '0;
      ack_wait_count <= '0;
      is_read        <= 1'b0;
      latched_addr   <= '0;
      latched_sub    <= '0;
      latched_data   <= '0;
      tx_stage       <= STAGE_ADDR;
    end else if (step) begin
      seq_state      <= seq_state_next;
      phase_count    <= phase_count_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      bytes_left     <= bytes_left_next;
      ack_wait_count <= ack_wait_count_next;
      is_read        <= is_read_next;
      latched_addr   <= latched_addr_next;
      latched_sub    <= latched_sub_next;
      latched_data   <= latched_data_next;
      tx_stage       <= tx_stage_next;
    end
  end

  assign plen     = (regs.phase_ticks == 8'd0) ? 8'd1 : regs.phase_ticks;
  assign pc_inc   = {1'b0, phase_count} + 9'd1;
  assign bc_inc   = bit_count + 4'd1;
  assign rx_shift = {shift_reg[6:0], item.sda_in};

  always_comb begin
    cnt = (item.read_count == 8'd0) ? 8'd1 : item.read_count;
    if (16'(cnt) > MaxRead) begin
      cnt = MaxRead[7:0];
    end
  end

  always_comb begin
    seq_state_next      = seq_state;
    phase_count_next    = phase_count;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    bytes_left_next     = bytes_left;
    ack_wait_count_next = ack_wait_count;
    is_read_next        = is_read;
    latched_addr_next   = latched_addr;
    latched_sub_next    = latched_sub;
    latched_data_next   = latched_data;
    tx_stage_next       = tx_stage;
    res                 = '0;

    if (seq_state == S_IDLE && (item.func == FUNC_WRITE || item.func == FUNC_READ)) begin
      latched_addr_next   = item.slave_addr;
      latched_sub_next    = item.sub_addr;
      latched_data_next   = item.write_data;
      is_read_next        = (item.func == FUNC_READ);
      bytes_left_next     = cnt;
      shift_reg_next      = {item.slave_addr, 1'b0};
      tx_stage_next       = STAGE_ADDR;
      bit_count_next      = '0;
      ack_wait_count_next = '0;
      seq_state_next      = S_START_SETUP;
      phase_count_next    = '0;
    end else if (seq_state == S_ACK_POLL && item.func == FUNC_TICK) begin
      if (!item.sda_in) begin
        bit_count_next   = '0;
        phase_count_next = '0;
        case (tx_stage)
          STAGE_ADDR: begin
            shift_reg_next = latched_sub;
            tx_stage_next  = STAGE_SUB;
            seq_state_next = S_TX_LOW;
          end
          STAGE_SUB: begin
            if (is_read) begin
              seq_state_next = S_RS_LOW;
            end else begin
              shift_reg_next = latched_data;
              tx_stage_next  = STAGE_DATA;
              seq_state_next = S_TX_LOW;
            end
          end
          STAGE_DATA: begin
            seq_state_next = S_STOP_LOW;
          end
          default: begin
            shift_reg_next = '0;
            seq_state_next = S_RX_LOW;
          end
        endcase
      end else if (ack_wait_count >= regs.ack_timeout) begin
        // Missing ACK: the failure flag rides in bit_count through STOP.
        bit_count_next   = 4'd1;
        seq_state_next   = S_STOP_LOW;
        phase_count_next = '0;
      end else begin
        ack_wait_count_next = ack_wait_count + 8'd1;
      end
    end else if (seq_state != S_IDLE && item.func == FUNC_TICK) begin
      phase_count_next = pc_inc[7:0];
      if (pc_inc >= {1'b0, plen}) begin
        phase_count_next = '0;
        case (seq_state)
          S_START_SETUP: seq_state_next = S_START_HOLD;
          S_START_HOLD: begin
            bit_count_next = '0;
            seq_state_next = S_TX_LOW;
          end
          S_TX_LOW: seq_state_next = S_TX_HIGH;
          S_TX_HIGH: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            if (bc_inc >= 4'd8) begin
              bit_count_next = '0;
              seq_state_next = S_ACK_LOW;
            end else begin
              bit_count_next = bc_inc;
              seq_state_next = S_TX_LOW;
            end
          end
          S_ACK_LOW: seq_state_next = S_ACK_HIGH;
          S_ACK_HIGH: begin
            ack_wait_count_next = '0;
            seq_state_next      = S_ACK_POLL;
          end
          S_RS_LOW: begin
            shift_reg_next = {latched_addr, 1'b1};
            tx_stage_next  = STAGE_RD_ADDR;
            seq_state_next = S_START_SETUP;
          end
          S_RX_LOW: seq_state_next = S_RX_HIGH;
          S_RX_HIGH: begin
            shift_reg_next = rx_shift;
            if (bc_inc >= 4'd8) begin
              bit_count_next = '0;
              res.read_data  = rx_shift;
              res.read_valid = 1'b1;
              res.read_last  = (bytes_left <= 8'd1);
              seq_state_next = S_MACK_LOW;
            end else begin
              bit_count_next = bc_inc;
              seq_state_next = S_RX_LOW;
            end
          end
          S_MACK_LOW: seq_state_next = S_MACK_HIGH;
          S_MACK_HIGH: begin
            if (bytes_left <= 8'd1) begin
              bytes_left_next = '0;
              bit_count_next  = '0;
              seq_state_next  = S_STOP_LOW;
            end else begin
              bytes_left_next = bytes_left - 8'd1;
              shift_reg_next  = '0;
              seq_state_next  = S_RX_LOW;
            end
          end
          S_STOP_LOW: seq_state_next = S_STOP_HIGH;
          S_STOP_HIGH: seq_state_next = S_STOP_REL;
          S_STOP_REL: begin
            res.done_res   = 1'b1;
            res.ok         = (bit_count == 4'd0);
            bit_count_next = '0;
            seq_state_next = S_IDLE;
          end
          default: seq_state_next = S_IDLE;
        endcase
      end
    end

    // Line levels follow the state reached after this item.
    last_byte_next = (bytes_left_next <= 8'd1);
    res.scl_out    = 1'b1;
    res.sda_out    = 1'b1;
    case (seq_state_next)
      S_START_HOLD: res.sda_out = 1'b0;
      S_TX_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = shift_reg_next[7];
      end
      S_TX_HIGH: res.sda_out = shift_reg_next[7];
      S_ACK_LOW, S_RS_LOW, S_RX_LOW: res.scl_out = 1'b0;
      S_MACK_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = last_byte_next;
      end
      S_MACK_HIGH: res.sda_out = last_byte_next;
      S_STOP_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b0;
      end
      S_STOP_HIGH: res.sda_out = 1'b0;
      default: ;
    endcase
    res.busy_res = (seq_state_next != S_IDLE);
  end

endmodule
